// File: rtl/core/vdle_pkg.sv
// ----------------------------------------------------------------------------
// Vector display list encoder package
// Shared command codes, word constants and item types for the encoder.
// ----------------------------------------------------------------------------
package vdle_pkg;

    // Command codes carried on the request type field.
    typedef enum logic [3:0] {
        REQ_VCTR_KEEP_Z  = 4'd0,
        REQ_VCTR_DARK    = 4'd1,
        REQ_VCTR_NEW_Z   = 4'd2,
        REQ_JMPL         = 4'd3,
        REQ_JSRL         = 4'd4,
        REQ_COLOR        = 4'd5,
        REQ_COLOR_FROM_Z = 4'd6,
        REQ_STAT         = 4'd7,
        REQ_SCALE        = 4'd8,
        REQ_CENTER       = 4'd9,
        REQ_HALT         = 4'd10,
        REQ_RTSL         = 4'd11,
        REQ_NEGATE       = 4'd12,
        REQ_SET_POINTER  = 4'd13
    } req_code_t;

    // Opcode bits of the emitted display list words.
    localparam logic [3:0]  JMPL_OPCODE   = 4'hE;
    localparam logic [3:0]  JSRL_OPCODE   = 4'hA;
    localparam logic [7:0]  COLOR_OPCODE  = 8'h64;
    localparam logic [7:0]  STAT_OPCODE   = 8'h60;
    localparam logic [3:0]  SCALE_OPCODE  = 4'h7;
    localparam logic [15:0] CENTER_WORD   = 16'h8040;
    localparam logic [15:0] HALT_WORD     = 16'h2020;
    localparam logic [15:0] RTSL_WORD     = 16'hC0C0;

    // Word counts an item can produce.
    localparam logic [1:0] NUM_WORDS_NONE = 2'd0;
    localparam logic [1:0] NUM_WORDS_ONE  = 2'd1;
    localparam logic [1:0] NUM_WORDS_TWO  = 2'd2;

    // One registered input item.
    typedef struct packed {
        logic [3:0]        req_type;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic [7:0]        operand_byte;
        logic [3:0]        scale_shift;
        logic [15:0]       target_addr;
        logic [15:0]       src_first_word;
        logic [15:0]       src_second_word;
    } req_t;

    // Encoded words of one item plus the updated list state.
    typedef struct packed {
        logic [1:0]  num_words;
        logic [15:0] addr0;
        logic [15:0] value0;
        logic [15:0] addr1;
        logic [15:0] value1;
        logic [15:0] pointer_next;
        logic [7:0]  z_next;
    } enc_t;

endpackage

// File: rtl/core/vdle_encoder.sv
// ----------------------------------------------------------------------------
// Vector display list encoder: command decode
// Turns one registered command into up to two list words and the next state.
// ----------------------------------------------------------------------------
module vdle_encoder (
    input  vdle_pkg::req_t   req_i,
    input  logic             flip_i,
    input  logic [15:0]      pointer_i,
    input  logic [7:0]       z_i,
    output vdle_pkg::enc_t   enc_o
);
    import vdle_pkg::*;

    // Optionally negate an 8-bit delta, sign-extend, shift left 2, keep 13 bits.
    function automatic logic [12:0] delta13(input logic [7:0] raw, input logic flip);
        logic [7:0] v;
        v = flip ? (8'd0 - raw) : raw;
        return {{3{v[7]}}, v, 2'b00};
    endfunction

    req_code_t   code;
    logic [7:0]  z_new;
    logic [12:0] dx13;
    logic [12:0] dy13;
    logic [11:0] jump_operand;

    assign code         = req_code_t'(req_i.req_type);
    assign dx13         = delta13(8'(req_i.delta_x), flip_i);
    assign dy13         = delta13(8'(req_i.delta_y), flip_i);
    assign jump_operand = req_i.target_addr[12:1];

    always_comb begin
        z_new = z_i;
        case (code)
            REQ_VCTR_DARK:  z_new = 8'd0;
            REQ_VCTR_NEW_Z: z_new = req_i.operand_byte;
            default:        z_new = z_i;
        endcase
    end

    always_comb begin
        enc_o.num_words = NUM_WORDS_ONE;
        enc_o.value0    = 16'd0;
        enc_o.value1    = 16'd0;
        enc_o.z_next    = z_new;
        case (code)
            REQ_VCTR_KEEP_Z, REQ_VCTR_DARK, REQ_VCTR_NEW_Z: begin
                enc_o.num_words = NUM_WORDS_TWO;
                enc_o.value0    = {3'b000, dy13};
                enc_o.value1    = {z_new[7:5], dx13};
            end
            REQ_JMPL:         enc_o.value0 = {JMPL_OPCODE, jump_operand};
            REQ_JSRL:         enc_o.value0 = {JSRL_OPCODE, jump_operand};
            REQ_COLOR:        enc_o.value0 = {COLOR_OPCODE, req_i.operand_byte};
            REQ_COLOR_FROM_Z: enc_o.value0 = {COLOR_OPCODE, z_i};
            REQ_STAT:         enc_o.value0 = {STAT_OPCODE, req_i.operand_byte};
            REQ_SCALE: begin
                enc_o.value0 = {SCALE_OPCODE, req_i.scale_shift, req_i.operand_byte};
            end
            REQ_CENTER:       enc_o.value0 = CENTER_WORD;
            REQ_HALT:         enc_o.value0 = HALT_WORD;
            REQ_RTSL:         enc_o.value0 = RTSL_WORD;
            REQ_NEGATE: begin
                enc_o.num_words = NUM_WORDS_TWO;
                enc_o.value0    = {3'b000, 13'(16'd0 - req_i.src_first_word)};
                enc_o.value1    = {3'b000, 13'(16'd0 - req_i.src_second_word)};
            end
            default: enc_o.num_words = NUM_WORDS_NONE;
        endcase

        // Each word takes two bytes of list space; set pointer loads it outright.
        enc_o.addr0 = pointer_i;
        enc_o.addr1 = pointer_i + 16'd2;
        if (code == REQ_SET_POINTER) begin
            enc_o.pointer_next = req_i.target_addr;
        end else begin
            enc_o.pointer_next = pointer_i + {13'd0, enc_o.num_words, 1'b0};
        end
    end

endmodule

// File: rtl/core/vector_display_list_encoder_unit.sv
// ----------------------------------------------------------------------------
// Vector display list encoder
// Encodes display commands into vector-generator words with byte addresses.
// ----------------------------------------------------------------------------
// The first word of an item passes through the input register and then the
// output register, where it waits while the port is still busy; a second word
// follows as soon as the first is taken. Throughput: one single-word command
// per cycle while m_ready holds; vector and negate commands give two words.
// Reset: synchronous, active low; clears flip, list pointer, z and all valids.
// ----------------------------------------------------------------------------
module vector_display_list_encoder_unit (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write channel.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_flip_screen,
    // Command input channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_req_type,
    input  logic signed [7:0] s_delta_x,
    input  logic signed [7:0] s_delta_y,
    input  logic [7:0]        s_operand_byte,
    input  logic [3:0]        s_scale_shift,
    input  logic [15:0]       s_target_addr,
    input  logic [15:0]       s_src_first_word,
    input  logic [15:0]       s_src_second_word,
    // Word output channel.
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_word_addr,
    output logic [15:0]       m_word_value,
    output logic              m_last_word
);
    import vdle_pkg::*;

    // Configuration and list state.
    logic        flip_reg;
    logic [15:0] pointer_reg;
    logic [7:0]  z_reg;

    // Input register: one command waiting to be encoded.
    logic        in_valid_reg;
    req_t        in_item_reg;

    // Output register holds the word on the port; the hold register keeps the
    // second word of a two-word command until the first one is taken.
    logic        out_valid_reg;
    logic [15:0] out_addr_reg;
    logic [15:0] out_value_reg;
    logic        out_last_reg;
    logic        hold_valid_reg;
    logic [15:0] hold_addr_reg;
    logic [15:0] hold_value_reg;

    enc_t        enc;
    logic        out_free;
    logic        advance;
    logic        load;
    logic        s_accept;
    logic        m_take;

    vdle_encoder u_encoder (
        .req_i     (in_item_reg),
        .flip_i    (flip_reg),
        .pointer_i (pointer_reg),
        .z_i       (z_reg),
        .enc_o     (enc)
    );

    // The output side can take a new command's words when it is empty, or when
    // its last pending word leaves in this cycle.
    assign out_free  = !out_valid_reg || (m_ready && !hold_valid_reg);
    // Commands that emit no words only update state and never wait on output.
    assign advance   = in_valid_reg && ((enc.num_words == NUM_WORDS_NONE) || out_free);
    assign load      = advance && (enc.num_words != NUM_WORDS_NONE);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign m_take    = out_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    assign m_valid      = out_valid_reg;
    assign m_word_addr  = out_addr_reg;
    assign m_word_value = out_value_reg;
    assign m_last_word  = out_last_reg;

    // Control state and list state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_reg       <= 1'b0;
            pointer_reg    <= 16'd0;
            z_reg          <= 8'd0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                flip_reg <= cfg_flip_screen;
            end
            if (advance) begin
                pointer_reg <= enc.pointer_next;
                z_reg       <= enc.z_next;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= (enc.num_words == NUM_WORDS_TWO);
            end else if (m_take) begin
                // Either the held second word moves up, or the port empties.
                out_valid_reg  <= hold_valid_reg;
                hold_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.req_type        <= s_req_type;
            in_item_reg.delta_x         <= s_delta_x;
            in_item_reg.delta_y         <= s_delta_y;
            in_item_reg.operand_byte    <= s_operand_byte;
            in_item_reg.scale_shift     <= s_scale_shift;
            in_item_reg.target_addr     <= s_target_addr;
            in_item_reg.src_first_word  <= s_src_first_word;
            in_item_reg.src_second_word <= s_src_second_word;
        end
        if (load) begin
            out_addr_reg   <= enc.addr0;
            out_value_reg  <= enc.value0;
            out_last_reg   <= (enc.num_words == NUM_WORDS_ONE);
            hold_addr_reg  <= enc.addr1;
            hold_value_reg <= enc.value1;
        end else if (m_take && hold_valid_reg) begin
            out_addr_reg  <= hold_addr_reg;
            out_value_reg <= hold_value_reg;
            out_last_reg  <= 1'b1;
        end
    end

    // A held second word always sits behind a first word that is not last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (out_valid_reg && !out_last_reg))
        else $error("hold word present without a leading first word");

    // Loading a two-word command leaves its second word held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (enc.num_words == NUM_WORDS_TWO)) |=> hold_valid_reg)
        else $error("second word of a two-word command was dropped");

    // When the first word leaves, the held word is shown next as the last word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_take && hold_valid_reg) |=>
            (out_valid_reg && out_last_reg && (out_addr_reg == $past(hold_addr_reg))))
        else $error("held word did not advance to the output");

endmodule
